[src/assert_macros.svh]
// Assertion helper macros, compiled out under SYNTHESIS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

[src/cle_pkg.sv]
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and codes for the circular list engine.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam logic [2:0] CMD_INS_FRONT = 3'd0;
  localparam logic [2:0] CMD_INS_BACK  = 3'd1;
  localparam logic [2:0] CMD_REM_FRONT = 3'd2;
  localparam logic [2:0] CMD_REM_BACK  = 3'd3;
  localparam logic [2:0] CMD_REM_AFTER = 3'd4;
  localparam logic [2:0] CMD_LIST      = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INSERT,
    S_REMF_RD,
    S_REMF,
    S_WALK_RD,
    S_WALK,
    S_REMB,
    S_MATCH_RD,
    S_MATCH,
    S_DEL_RD,
    S_DEL,
    S_LIST_RD,
    S_LIST,
    S_REPORT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;       // capture command and value
    logic       rd_head;    // read address = head
    logic       rd_link;    // read address = link of pointer node
    logic       rd_en;
    logic       do_insert;
    logic       do_remf;
    logic       step;       // ptr <= link, idx++
    logic       do_remb;
    logic       do_del;
    logic       rem_single;
    logic       emit;
    logic [1:0] status;
    logic       item;       // emit carries the read value
    logic       last;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       empty;
    logic       single;
    logic       full;
    logic       link_is_tail; // read link equals tail
    logic       match;        // read value equals target
    logic       ptr_is_tail;
    logic       idx_end;      // idx + 1 == count
  } stat_t;

endpackage

[src/cle_ram.sv]
// ----------------------------------------------------------------------------
// cle_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module cle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

[src/cle_datapath.sv]
// ----------------------------------------------------------------------------
// cle_datapath
// Node pool, free map, head/tail/count registers and the walking pointer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cle_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          command,
  input  logic signed [31:0]  value,
  input  cle_pkg::ctrl_t      ctrl,
  output cle_pkg::stat_t      stat,
  output logic                strobe,
  output logic [1:0]          status,
  output logic signed [31:0]  item_value,
  output logic                last,
  output logic [$clog2(CAPACITY+1)-1:0] element_count
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY+1);

  logic [2:0]    cmd;
  logic [31:0]   target;
  logic [AW-1:0] head, tail, ptr, prev;
  logic [CW-1:0] count, idx;
  logic [CAPACITY-1:0] free_map;
  logic [AW-1:0] free_idx;
  logic          any_free;

  logic [31:0]   rd_val;
  logic [AW-1:0] rd_lnk;
  logic          v_we, l_we, rd_en;
  logic [AW-1:0] v_wa, l_wa, l_wd, raddr;

  // lowest free node
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = CAPACITY-1; i >= 0; i--) begin
      if (free_map[i]) begin
        free_idx = AW'(i);
        any_free = 1'b1;
      end
    end
  end

  always_comb begin
    if (ctrl.rd_head)      raddr = head;
    else if (ctrl.rd_link) raddr = rd_lnk;
    else                   raddr = ptr;
  end
  assign rd_en = ctrl.rd_en;

  // writes: insert writes value and link of new node; the tail link write
  // for insert and the other link updates go through the link port
  always_comb begin
    v_we = ctrl.do_insert;
    v_wa = free_idx;
    l_we = 1'b0;
    l_wa = ptr;
    l_wd = head;
    if (ctrl.do_insert) begin
      l_we = 1'b1;
      l_wa = free_idx;
      l_wd = (count == '0) ? free_idx : head;
    end else if (ctrl.do_remf) begin
      l_we = 1'b1;
      l_wa = tail;
      l_wd = rd_lnk;
    end else if (ctrl.do_remb) begin
      l_we = 1'b1;
      l_wa = ptr;
      l_wd = head;
    end else if (ctrl.do_del) begin
      l_we = 1'b1;
      l_wa = ptr;
      l_wd = rd_lnk;
    end
  end

  // tail link fix after insert into a non-empty list, done in the following cycle
  logic          fix_pend;
  logic [AW-1:0] fix_node, fix_tail;

  logic          lw_we;
  logic [AW-1:0] lw_wa, lw_wd;
  always_comb begin
    lw_we = l_we;
    lw_wa = l_wa;
    lw_wd = l_wd;
    if (fix_pend) begin
      lw_we = 1'b1;
      lw_wa = fix_tail;
      lw_wd = fix_node;
    end
  end

  cle_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_vals (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(target),
    .re(rd_en), .raddr(raddr), .rdata(rd_val)
  );
  cle_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_links (
    .clk(clk), .we(lw_we), .waddr(lw_wa), .wdata(lw_wd),
    .re(rd_en), .raddr(raddr), .rdata(rd_lnk)
  );

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      target <= value;
    end
    fix_node <= free_idx;
    fix_tail <= tail;
    if (ctrl.rd_head) begin
      ptr <= head;
      idx <= '0;
    end else if (ctrl.step) begin
      prev <= ptr;
      ptr  <= rd_lnk;
      idx  <= idx + CW'(1);
    end else if (ctrl.rd_link) begin
      // successor of the match node, the one to be unlinked
      prev <= rd_lnk;
    end
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      free_map <= '1;
      fix_pend <= 1'b0;
      strobe   <= 1'b0;
      cmd      <= '0;
    end else begin
      if (ctrl.load) begin
        cmd <= command;
      end
      fix_pend <= ctrl.do_insert && (count != '0);
      strobe   <= ctrl.emit;
      if (ctrl.emit) begin
        status     <= ctrl.status;
        item_value <= ctrl.item ? rd_val : '0;
        last       <= ctrl.last;
      end
      if (ctrl.do_insert) begin
        free_map[free_idx] <= 1'b0;
        count <= count + CW'(1);
        if (count == '0) begin
          head <= free_idx;
          tail <= free_idx;
        end else if (cmd == cle_pkg::CMD_INS_FRONT) begin
          head <= free_idx;
        end else begin
          tail <= free_idx;
        end
      end
      if (ctrl.rem_single) begin
        free_map[head] <= 1'b1;
        head  <= '0;
        tail  <= '0;
        count <= '0;
      end
      if (ctrl.do_remf) begin
        free_map[head] <= 1'b1;
        head  <= rd_lnk;
        count <= count - CW'(1);
      end
      if (ctrl.do_remb) begin
        free_map[tail] <= 1'b1;
        tail  <= ptr;
        count <= count - CW'(1);
      end
      if (ctrl.do_del) begin
        // ptr = match node, prev holds the deleted node index
        free_map[prev] <= 1'b1;
        if (prev == tail) tail <= ptr;
        count <= count - CW'(1);
      end
    end
  end

  assign element_count = count;

  always_comb begin
    stat.cmd          = cmd;
    stat.empty        = (count == '0);
    stat.single       = (count == CW'(1));
    stat.full         = !any_free;
    stat.link_is_tail = (rd_lnk == tail);
    stat.match        = (rd_val == target);
    stat.ptr_is_tail  = (ptr == tail);
    stat.idx_end      = (idx + CW'(1) == count);
  end

  `ASSERT_IMPL(a_count_range, clk, rst, count <= CW'(CAPACITY))
  `ASSERT_IMPL(a_free_count, clk, rst,
    $countones(free_map) + count == CAPACITY)
  `ASSERT_IMPL(a_one_update, clk, rst,
    $onehot0({ctrl.do_insert, ctrl.do_remf, ctrl.do_remb, ctrl.do_del,
              ctrl.rem_single}))
endmodule

[src/cle_ctrl.sv]
// ----------------------------------------------------------------------------
// cle_ctrl
// Command sequencer: decodes, walks the list one node read at a time,
// commits updates and issues result beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cle_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  cle_pkg::stat_t stat,
  output cle_pkg::ctrl_t ctrl
);
  cle_pkg::state_t state, state_next;
  logic [1:0] rstat, rstat_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cle_pkg::S_IDLE;
      rstat <= cle_pkg::ST_OK;
    end else begin
      state <= state_next;
      rstat <= rstat_next;
    end
  end

  always_comb begin
    state_next = state;
    rstat_next = rstat;
    ctrl = '0;
    busy = (state != cle_pkg::S_IDLE);
    unique case (state)
      cle_pkg::S_IDLE: begin
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = cle_pkg::S_DECODE;
        end
      end
      cle_pkg::S_DECODE: begin
        rstat_next = cle_pkg::ST_OK;
        state_next = cle_pkg::S_REPORT;
        unique case (stat.cmd) inside
          cle_pkg::CMD_INS_FRONT, cle_pkg::CMD_INS_BACK: begin
            if (stat.full) rstat_next = cle_pkg::ST_FULL;
            else           state_next = cle_pkg::S_INSERT;
          end
          cle_pkg::CMD_REM_FRONT, cle_pkg::CMD_REM_BACK: begin
            if (stat.empty) rstat_next = cle_pkg::ST_EMPTY;
            else if (stat.single) ctrl.rem_single = 1'b1;
            else begin
              ctrl.rd_head = 1'b1;
              ctrl.rd_en   = 1'b1;
              state_next = (stat.cmd == cle_pkg::CMD_REM_FRONT) ?
                           cle_pkg::S_REMF : cle_pkg::S_WALK;
            end
          end
          cle_pkg::CMD_REM_AFTER: begin
            if (stat.empty) rstat_next = cle_pkg::ST_EMPTY;
            else begin
              ctrl.rd_head = 1'b1;
              ctrl.rd_en   = 1'b1;
              state_next   = cle_pkg::S_MATCH;
            end
          end
          cle_pkg::CMD_LIST: begin
            if (stat.empty) rstat_next = cle_pkg::ST_EMPTY;
            else begin
              ctrl.rd_head = 1'b1;
              ctrl.rd_en   = 1'b1;
              state_next   = cle_pkg::S_LIST;
            end
          end
          default: ;
        endcase
      end
      cle_pkg::S_INSERT: begin
        ctrl.do_insert = 1'b1;
        state_next     = cle_pkg::S_REMF_RD;  // spare cycle for the tail link fix
      end
      cle_pkg::S_REMF_RD: state_next = cle_pkg::S_REPORT;
      cle_pkg::S_REMF: begin
        ctrl.do_remf = 1'b1;
        state_next   = cle_pkg::S_REPORT;
      end
      cle_pkg::S_WALK: begin
        // rd data is node ptr; stop when its link is the tail
        if (stat.link_is_tail) begin
          ctrl.do_remb = 1'b1;
          state_next   = cle_pkg::S_REPORT;
        end else begin
          ctrl.step  = 1'b1;
          state_next = cle_pkg::S_WALK_RD;
        end
      end
      cle_pkg::S_WALK_RD: begin
        ctrl.rd_en = 1'b1;
        state_next = cle_pkg::S_WALK;
      end
      cle_pkg::S_MATCH: begin
        if (stat.match) begin
          if (stat.ptr_is_tail) begin
            rstat_next = cle_pkg::ST_NOTFOUND;
            state_next = cle_pkg::S_REPORT;
          end else begin
            ctrl.rd_link = 1'b1;
            ctrl.rd_en   = 1'b1;
            state_next   = cle_pkg::S_DEL_RD;
          end
        end else if (stat.idx_end) begin
          rstat_next = cle_pkg::ST_NOTFOUND;
          state_next = cle_pkg::S_REPORT;
        end else begin
          ctrl.step  = 1'b1;
          state_next = cle_pkg::S_MATCH_RD;
        end
      end
      cle_pkg::S_MATCH_RD: begin
        ctrl.rd_en = 1'b1;
        state_next = cle_pkg::S_MATCH;
      end
      cle_pkg::S_DEL_RD: begin
        // deleted node's link on its way out of the RAM; prev = del, ptr = match
        state_next = cle_pkg::S_DEL;
      end
      cle_pkg::S_DEL: begin
        ctrl.do_del = 1'b1;
        state_next  = cle_pkg::S_REPORT;
      end
      cle_pkg::S_LIST: begin
        ctrl.emit   = 1'b1;
        ctrl.item   = 1'b1;
        ctrl.status = cle_pkg::ST_OK;
        if (stat.idx_end) begin
          ctrl.last  = 1'b1;
          state_next = cle_pkg::S_IDLE;
        end else begin
          ctrl.step  = 1'b1;
          state_next = cle_pkg::S_LIST_RD;
        end
      end
      cle_pkg::S_LIST_RD: begin
        ctrl.rd_en = 1'b1;
        state_next = cle_pkg::S_LIST;
      end
      cle_pkg::S_REPORT: begin
        ctrl.emit   = 1'b1;
        ctrl.status = rstat;
        ctrl.last   = 1'b1;
        state_next  = cle_pkg::S_IDLE;
      end
      default: state_next = cle_pkg::S_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_no_start_busy, clk, rst,
    (busy && start) |=> state != cle_pkg::S_DECODE || $past(state) == cle_pkg::S_IDLE)
  `ASSERT_IMPL(a_emit_last_idle, clk, rst, (ctrl.emit && ctrl.last) |=> !busy)
  `ASSERT_IMPL(a_load_idle, clk, rst, ctrl.load |-> state == cle_pkg::S_IDLE)
endmodule

[src/circular_list_engine.sv]
// ----------------------------------------------------------------------------
// circular_list_engine
// Bounded circular singly linked list of signed 32-bit values.
// ----------------------------------------------------------------------------
// A command (command, value) is taken at a clock edge with start high and busy
// low. busy stays high until the cycle of the command's last result beat.
// Each result beat shows on status, item_value, last and element_count for
// one cycle with strobe high; the receiver cannot stall, so the block never
// waits on it. After the accepting edge, an insert passes the DECODE, INSERT,
// REMF_RD and REPORT states before its registered beat, a remove-front DECODE,
// REMF and REPORT, and the empty, full, single-element and unknown-command
// answers DECODE and REPORT. Remove-back and remove-after walk the links one
// node read at a time from the single read port of the node RAMs, a read state
// and a check state per node. List-all gives one beat per node from the head,
// the last on the tail. An empty list-all gives one beat with the empty status.
// Reset empties the list at once: all nodes free, count zero; node contents
// are not cleared, and only written nodes are ever read. busy is already low
// during the last beat, so the next command may be taken at the edge ending it.
// ----------------------------------------------------------------------------
module circular_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          command,
  input  logic signed [31:0]  value,
  output logic                strobe,
  output logic [1:0]          status,
  output logic signed [31:0]  item_value,
  output logic                last,
  output logic [$clog2(CAPACITY+1)-1:0] element_count
);
  cle_pkg::ctrl_t ctrl;
  cle_pkg::stat_t stat;

  cle_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .stat(stat), .ctrl(ctrl)
  );

  cle_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst(rst), .command(command), .value(value),
    .ctrl(ctrl), .stat(stat), .strobe(strobe), .status(status),
    .item_value(item_value), .last(last), .element_count(element_count)
  );
endmodule
